>>> sv/xsu_pkg.sv
`timescale 1ns / 1ps

package xsu_pkg;

  localparam int LANES  = 16;
  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

  localparam int SHIFT_A    = 9;
  localparam int ROT_B      = 11;
  localparam int FRAC_W     = 23;
  localparam int JUMP_STEPS = 128;
  localparam int STEP_W     = $clog2(JUMP_STEPS);

  // Register index, taken from paddr[2]
  localparam logic [0:0] REG_SEED = 1'b0;

  // Jump polynomial, bit 32*k+b is bit b of word k
  localparam logic [JUMP_STEPS-1:0] JUMP_POLY =
    {32'h77f2db5b, 32'h6fa035c3, 32'hf542d2d3, 32'h8764000b};

  typedef logic [3:0][31:0] lane_t;

  typedef struct packed {
    logic              en;
    logic [LANE_W-1:0] addr;
    lane_t             data;
  } lane_wr_t;

  // One xoshiro128 step
  function automatic lane_t advance(lane_t w);
    lane_t       n;
    logic [31:0] t;
    t    = w[1] << SHIFT_A;
    n    = w;
    n[2] = n[2] ^ n[0];
    n[3] = n[3] ^ n[1];
    n[1] = n[1] ^ n[2];
    n[0] = n[0] ^ n[3];
    n[2] = n[2] ^ t;
    n[3] = {n[3][31-ROT_B:0], n[3][31:32-ROT_B]};
    return n;
  endfunction

  // Word k of lane i: seed + 100k + 31 - i, mod 2^32
  function automatic lane_t seed_lane(logic [31:0] s, logic [LANE_W-1:0] i);
    lane_t w;
    for (int k = 0; k < 4; k++) begin
      w[k] = s + 32'(100 * k + 31) - 32'(i);
    end
    return w;
  endfunction

endpackage

>>> sv/xsu_lane_ram.sv
`timescale 1ns / 1ps

module xsu_lane_ram (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [xsu_pkg::LANE_W-1:0] rd_addr,
  output xsu_pkg::lane_t             rd_data,
  input  xsu_pkg::lane_wr_t          wr
);

  xsu_pkg::lane_t                mem [xsu_pkg::LANES];
  logic [xsu_pkg::LANES-1:0]     written;
  xsu_pkg::lane_t                rd_q;
  logic                          rd_written;

  // Unwritten lanes read as all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign rd_data = rd_written ? rd_q : '0;

endmodule

>>> sv/multilane_xoshiro_uniform_float.sv
`timescale 1ns / 1ps

// Sixteen independent xoshiro128+ generators kept in a lane memory of 16
// entries by 128 bits. A draw word (action = 1) reads the current lane (lane
// 0 when restart_lane is set, otherwise the lane counter), returns the top
// 23 bits of word0 + word3 as an unsigned 0.23 fraction, steps the lane and
// writes it back; a draw first does the synchronous memory read and then the
// update and write-back, and it holds the update while an earlier result
// still sits stalled in the output register. A reseed word (action = 0)
// produces no result: every lane is loaded from the seed register (word k
// of lane i is seed + 100k + 31 - i) and jumped ahead 2^64 steps by a loop
// that applies one generator step per cycle, with no item accepted
// meanwhile.
// Lanes never written read as zero and draw fraction 0. The seed register
// sits at APB byte address 0; write it only while the block is idle.
module multilane_xoshiro_uniform_float (
  input  logic                        clk,
  input  logic                        rst,
  // item channel
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic                        action,
  input  logic                        restart_lane,
  // result channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [xsu_pkg::FRAC_W-1:0]  fraction,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DRAW = 3'b010,
    ST_JUMP = 3'b100
  } state_t;

  state_t                        state;
  logic [31:0]                   seed;
  logic [xsu_pkg::LANE_W-1:0]    lane_cnt;
  logic [xsu_pkg::LANE_W-1:0]    draw_lane;
  logic [xsu_pkg::LANE_W-1:0]    jump_lane;
  logic [xsu_pkg::STEP_W-1:0]    step_cnt;
  xsu_pkg::lane_t                jw;
  xsu_pkg::lane_t                acc;

  logic                          item_acc;
  logic                          out_free;
  logic                          last_step;
  logic                          last_lane;
  logic [xsu_pkg::LANE_W-1:0]    sel_lane;
  logic [31:0]                   sum;
  xsu_pkg::lane_t                rd_data;
  xsu_pkg::lane_t                acc_next;
  xsu_pkg::lane_wr_t             lane_wr;

  // Configuration port: single register, always ready
  assign pready = 1'b1;
  assign prdata = (paddr[2] == xsu_pkg::REG_SEED) ? seed : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (psel && penable && pwrite && paddr[2] == xsu_pkg::REG_SEED) begin
      seed <= pwdata;
    end
  end

  // Handshake and lane selection
  assign item_stall = (state != ST_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign sel_lane   = restart_lane ? '0 : lane_cnt;
  assign last_step  = (step_cnt == xsu_pkg::STEP_W'(xsu_pkg::JUMP_STEPS - 1));
  assign last_lane  = (jump_lane == xsu_pkg::LANE_W'(xsu_pkg::LANES - 1));

  // Draw datapath: lane word arrives in the cycle after the read
  assign sum = rd_data[0] + rd_data[3];

  // Jump: fold the current state into the accumulator on each set poly bit
  assign acc_next = xsu_pkg::JUMP_POLY[step_cnt] ? (acc ^ jw) : acc;

  // Single write port: draw write-back or finished jump
  always_comb begin
    lane_wr = '0;
    priority if (state == ST_DRAW && out_free) begin
      lane_wr.en   = 1'b1;
      lane_wr.addr = draw_lane;
      lane_wr.data = xsu_pkg::advance(rd_data);
    end else if (state == ST_JUMP && last_step) begin
      lane_wr.en   = 1'b1;
      lane_wr.addr = jump_lane;
      lane_wr.data = acc_next;
    end else begin
      lane_wr = '0;
    end
  end

  xsu_lane_ram u_lane_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (item_acc && action),
    .rd_addr (sel_lane),
    .rd_data (rd_data),
    .wr      (lane_wr)
  );

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      lane_cnt     <= '0;
      result_valid <= 1'b0;
      step_cnt     <= '0;
      jump_lane    <= '0;
    end else begin
      // raise on a finished draw, drop once the receiver takes the word
      if (state == ST_DRAW && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_acc) begin
            if (action) begin
              // advance the lane counter at accept, wrap after the last lane
              lane_cnt <= (sel_lane == xsu_pkg::LANE_W'(xsu_pkg::LANES - 1)) ?
                          '0 : sel_lane + 1'b1;
              state    <= ST_DRAW;
            end else begin
              step_cnt  <= '0;
              jump_lane <= '0;
              state     <= ST_JUMP;
            end
          end
        end
        ST_DRAW: begin
          // hold until the output register can take the result
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_JUMP: begin
          step_cnt <= step_cnt + 1'b1;
          if (last_step) begin
            if (last_lane) begin
              state <= ST_IDLE;
            end else begin
              jump_lane <= jump_lane + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_acc) begin
      draw_lane <= sel_lane;
      jw        <= xsu_pkg::seed_lane(seed, '0);
      acc       <= '0;
    end
    if (state == ST_DRAW && out_free) begin
      fraction <= sum[31 -: xsu_pkg::FRAC_W];
    end
    if (state == ST_JUMP) begin
      if (last_step) begin
        // load the next lane's seed words and restart the sum
        jw  <= xsu_pkg::seed_lane(seed, jump_lane + 1'b1);
        acc <= '0;
      end else begin
        jw  <= xsu_pkg::advance(jw);
        acc <= acc_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_result_from_draw: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_DRAW))
    else $error("result raised outside a draw");

  a_write_owner: assert property (@(posedge clk) disable iff (rst)
    lane_wr.en |-> (state == ST_DRAW || state == ST_JUMP))
    else $error("lane write while idle");

  a_step_advance: assert property (@(posedge clk) disable iff (rst)
    (state == ST_JUMP && !last_step) |=>
      (state == ST_JUMP && step_cnt == $past(step_cnt) + 1'b1))
    else $error("jump loop lost a step");

  a_lane_range: assert property (@(posedge clk) disable iff (rst)
    (32'(lane_cnt) < xsu_pkg::LANES) && (32'(jump_lane) < xsu_pkg::LANES))
    else $error("lane index out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(fraction)))
    else $error("stalled result lost or overwritten");
`endif

endmodule
